>>> sv/rrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants of the round-robin scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 16;

  localparam int CNT_BITS = 16;
  localparam int CFG_BITS = 16;

  localparam logic [CFG_BITS-1:0] QUANTUM_RESET = 16'd100;
  localparam logic [CFG_BITS-1:0] TOTAL_RESET   = 16'd1;

  localparam logic CFG_SLICE_LIMIT   = 1'b0;
  localparam logic CFG_PROCESS_TOTAL = 1'b1;

  typedef enum logic [2:0] {
    MODE_READY   = 3'd0,
    MODE_IO_DONE = 3'd1,
    MODE_IO_REQ  = 3'd2,
    MODE_TERM    = 3'd3,
    MODE_TICK    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNEXPECTED = 2'd1,
    ST_FULL       = 2'd2,
    ST_AFTER_DONE = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> sv/round_robin_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_scheduler
// Round-robin process scheduler with a time quantum and a FIFO ready queue.
// ----------------------------------------------------------------------------
// A beat taken is held in the input register, then decoded together with the
// queue update, and its result is strobed from the result register.
// Throughput: one event per cycle; busy stays low, results cannot be held off.
// Reset: queue emptied, nothing running, counters cleared,
// slice limit 100 and process_total 1.
module round_robin_scheduler
  import rrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          mode,
  input  logic [ID_BITS-1:0]  proc_id,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  output logic                result_valid,
  output logic                dispatch_valid,
  output logic [ID_BITS-1:0]  dispatch_id,
  output logic                preempt_valid,
  output logic [ID_BITS-1:0]  preempt_id,
  output logic                all_done,
  output logic [1:0]          status
);

  logic                in_valid;
  logic [2:0]          in_mode;
  logic [ID_BITS-1:0]  in_id;
  logic [CFG_BITS-1:0] slice_limit;
  logic [CFG_BITS-1:0] process_total;
  q_req_t              qreq;
  q_stat_t             qstat;
  logic [ID_BITS-1:0]  push_data;
  logic [ID_BITS-1:0]  head_data;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_mode <= mode;
    in_id   <= proc_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_limit   <= QUANTUM_RESET;
      process_total <= TOTAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SLICE_LIMIT:   slice_limit   <= cfg_data;
        CFG_PROCESS_TOTAL: process_total <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rrs_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .req       (qreq),
    .push_data (push_data),
    .stat      (qstat),
    .head_data (head_data)
  );

  rrs_ctrl #(
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_mode        (in_mode),
    .in_id          (in_id),
    .slice_limit    (slice_limit),
    .process_total  (process_total),
    .qstat          (qstat),
    .head_data      (head_data),
    .qreq           (qreq),
    .push_data      (push_data),
    .result_valid   (result_valid),
    .dispatch_valid (dispatch_valid),
    .dispatch_id    (dispatch_id),
    .preempt_valid  (preempt_valid),
    .preempt_id     (preempt_id),
    .all_done       (all_done),
    .status         (status)
  );

endmodule

>>> sv/rrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_queue
// Ready queue: circular buffer with head, tail and fill count, and a
// registered copy of the entry at the head.
// ----------------------------------------------------------------------------
module rrs_queue
  import rrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  q_req_t             req,
  input  logic [ID_BITS-1:0] push_data,
  output q_stat_t            stat,
  output logic [ID_BITS-1:0] head_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   head_next;
  logic [PTR_W-1:0]   tail_next;
  logic [CNT_W-1:0]   count_next;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_next  = req.pop  ? wrap_inc(head) : head;
    tail_next  = req.push ? wrap_inc(tail) : tail;
    count_next = count + CNT_W'(req.push) - CNT_W'(req.pop);
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // The head copy is refreshed every cycle; a write that lands on the new
  // head slot is forwarded so the copy never goes stale.
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail] <= push_data;
    end
    if (req.push && (tail == head_next)) begin
      head_data <= push_data;
    end else begin
      head_data <= mem[head_next];
    end
  end

endmodule

>>> sv/rrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_ctrl
// Event decode, running-process state, quantum and termination counters,
// and the result register.
// ----------------------------------------------------------------------------
module rrs_ctrl
  import rrs_pkg::*;
#(
  parameter int ID_BITS = DEF_ID_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          in_mode,
  input  logic [ID_BITS-1:0]  in_id,
  input  logic [CFG_BITS-1:0] slice_limit,
  input  logic [CFG_BITS-1:0] process_total,
  input  q_stat_t             qstat,
  input  logic [ID_BITS-1:0]  head_data,
  output q_req_t              qreq,
  output logic [ID_BITS-1:0]  push_data,
  output logic                result_valid,
  output logic                dispatch_valid,
  output logic [ID_BITS-1:0]  dispatch_id,
  output logic                preempt_valid,
  output logic [ID_BITS-1:0]  preempt_id,
  output logic                all_done,
  output logic [1:0]          status
);

  logic                running;
  logic [ID_BITS-1:0]  current_id;
  logic [CNT_BITS-1:0] slice_ticks;
  logic [CNT_BITS-1:0] finished_count;

  logic                running_next;
  logic [ID_BITS-1:0]  current_id_next;
  logic [CNT_BITS-1:0] slice_ticks_next;
  logic [CNT_BITS-1:0] finished_count_next;
  logic                disp_v;
  logic [ID_BITS-1:0]  disp_id;
  logic                pre_v;
  logic [ID_BITS-1:0]  pre_id;
  status_t             st;
  logic                done_next;

  always_comb begin
    logic                done_now;
    logic [CNT_BITS-1:0] tick_cnt;
    done_now            = (finished_count >= process_total);
    tick_cnt            = '0;
    running_next        = running;
    current_id_next     = current_id;
    slice_ticks_next    = slice_ticks;
    finished_count_next = finished_count;
    qreq                = '0;
    push_data           = in_id;
    disp_v              = 1'b0;
    disp_id             = '0;
    pre_v               = 1'b0;
    pre_id              = '0;
    st                  = ST_OK;

    if (done_now) begin
      st = ST_AFTER_DONE;
    end else begin
      case (mode_t'(in_mode))
        MODE_READY, MODE_IO_DONE: begin
          if (qstat.full) begin
            st = ST_FULL;
          end else begin
            qreq.push = 1'b1;
          end
        end
        MODE_IO_REQ, MODE_TERM: begin
          if (running && (in_id == current_id)) begin
            running_next = 1'b0;
            if ((mode_t'(in_mode) == MODE_TERM) && (finished_count != '1)) begin
              finished_count_next = finished_count + 1'b1;
            end
          end else begin
            st = ST_UNEXPECTED;
          end
        end
        MODE_TICK: begin
          if (running) begin
            tick_cnt         = (slice_ticks == '1) ? slice_ticks : slice_ticks + 1'b1;
            slice_ticks_next = tick_cnt;
            if (tick_cnt >= slice_limit) begin
              pre_v  = 1'b1;
              pre_id = current_id;
              // Requeue the preempted process behind the new head.
              if (!qstat.empty) begin
                qreq.pop        = 1'b1;
                qreq.push       = 1'b1;
                push_data       = current_id;
                current_id_next = head_data;
              end
              slice_ticks_next = '0;
              disp_v           = 1'b1;
              disp_id          = current_id_next;
            end
          end
        end
        default: begin
          st = ST_UNEXPECTED;
        end
      endcase
    end

    done_next = (finished_count_next >= process_total);

    // An idle CPU takes the head; an empty queue that was just pushed hands
    // the new id straight through.
    if ((st != ST_AFTER_DONE) && !running_next && (!qstat.empty || qreq.push) &&
        !done_next) begin
      qreq.pop         = 1'b1;
      current_id_next  = qstat.empty ? push_data : head_data;
      running_next     = 1'b1;
      slice_ticks_next = '0;
      disp_v           = 1'b1;
      disp_id          = current_id_next;
    end

    if (!in_valid) begin
      qreq = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      current_id     <= '0;
      slice_ticks    <= '0;
      finished_count <= '0;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= in_valid;
      if (in_valid) begin
        running        <= running_next;
        current_id     <= current_id_next;
        slice_ticks    <= slice_ticks_next;
        finished_count <= finished_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    dispatch_valid <= disp_v;
    dispatch_id    <= disp_id;
    preempt_valid  <= pre_v;
    preempt_id     <= pre_id;
    all_done       <= done_next;
    status         <= st;
  end

endmodule

>>> sv/rrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_checker
// Port-level checks of the round-robin scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrs_checker
  import rrs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic       dispatch_valid,
  input logic       preempt_valid,
  input logic       all_done,
  input logic [1:0] status
);

  // Every accepted beat yields exactly one result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 result_valid)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted beat");

  a_preempt_redispatch: assert property (@(posedge clk) disable iff (rst)
    (result_valid && preempt_valid) |-> (dispatch_valid && (status == ST_OK)))
    else $error("preemption without a dispatch");

  a_after_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == ST_AFTER_DONE)) |->
      (all_done && !dispatch_valid && !preempt_valid))
    else $error("activity after all processes finished");

endmodule

bind round_robin_scheduler rrs_checker u_rrs_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .result_valid   (result_valid),
  .dispatch_valid (dispatch_valid),
  .preempt_valid  (preempt_valid),
  .all_done       (all_done),
  .status         (status)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin scheduler. A queue of events feeds
// a driver with random gaps, and an in-bench scheduler model predicts every
// result. The run covers directed corner cases and several random phases
// under different quantum and termination-total settings.
// ----------------------------------------------------------------------------
module tb_top;
  import rrs_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] id;
    bit          aim;
  } sched_event_t;

  typedef struct {
    logic        dispatch_valid;
    logic [15:0] dispatch_id;
    logic        preempt_valid;
    logic [15:0] preempt_id;
    logic        all_done;
    status_t     status;
  } sched_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = '0;
  logic [15:0] proc_id = '0;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        result_valid;
  logic        dispatch_valid;
  logic [15:0] dispatch_id;
  logic        preempt_valid;
  logic [15:0] preempt_id;
  logic        all_done;
  logic [1:0]  status;

  // Scheduler model state.
  logic [15:0] rq_mem [DEPTH];
  int unsigned rq_head, rq_tail, rq_count;
  bit          cpu_busy;
  logic [15:0] cpu_id;
  int unsigned slice_cnt, term_cnt, quantum_reg, total_reg;

  sched_event_t   event_q [$];
  sched_outcome_t outcome_q [$];
  sched_event_t   next_ev;
  sched_outcome_t got_outcome;
  sched_outcome_t want;

  bit beat_taken = 1'b0;
  int gap_left = 0;
  int events_queued = 0;
  int events_accepted = 0;
  int errors = 0;
  int n_dispatch = 0, n_preempt = 0, n_full = 0, n_unexp = 0, n_after = 0;

  round_robin_scheduler dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .proc_id       (proc_id),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .dispatch_valid(dispatch_valid),
    .dispatch_id   (dispatch_id),
    .preempt_valid (preempt_valid),
    .preempt_id    (preempt_id),
    .all_done      (all_done),
    .status        (status)
  );

  always #10 clk = ~clk;

  function automatic bit rq_push(logic [15:0] id);
    if (rq_count >= DEPTH) return 1'b0;
    rq_mem[rq_tail] = id;
    rq_tail = (rq_tail + 1) % DEPTH;
    rq_count++;
    return 1'b1;
  endfunction

  function automatic logic [15:0] rq_pop();
    logic [15:0] id;
    id = rq_mem[rq_head];
    rq_head = (rq_head + 1) % DEPTH;
    rq_count--;
    return id;
  endfunction

  // Applies one event to the model and returns the outcome the block must show.
  function automatic sched_outcome_t schedule_event(logic [2:0] ev_mode, logic [15:0] ev_id);
    sched_outcome_t r;
    logic [15:0] nxt;
    r = '{1'b0, 16'h0, 1'b0, 16'h0, 1'b0, ST_OK};
    if (term_cnt >= total_reg) begin
      r.status = ST_AFTER_DONE;
    end else begin
      case (ev_mode)
        MODE_READY, MODE_IO_DONE: begin
          if (!rq_push(ev_id)) r.status = ST_FULL;
        end
        MODE_IO_REQ, MODE_TERM: begin
          if (cpu_busy && ev_id == cpu_id) begin
            cpu_busy = 1'b0;
            if (ev_mode == MODE_TERM && term_cnt < 16'hFFFF) term_cnt++;
          end else begin
            r.status = ST_UNEXPECTED;
          end
        end
        MODE_TICK: begin
          if (cpu_busy) begin
            if (slice_cnt < 16'hFFFF) slice_cnt++;
            if (slice_cnt >= quantum_reg) begin
              r.preempt_valid = 1'b1;
              r.preempt_id = cpu_id;
              // The head leaves first, so a full queue still takes the
              // preempted process back.
              if (rq_count > 0) begin
                nxt = rq_pop();
                void'(rq_push(cpu_id));
                cpu_id = nxt;
              end
              slice_cnt = 0;
              r.dispatch_valid = 1'b1;
              r.dispatch_id = cpu_id;
            end
          end
        end
        default: r.status = ST_UNEXPECTED;
      endcase
    end
    if (r.status != ST_AFTER_DONE && !cpu_busy && rq_count > 0 && term_cnt < total_reg) begin
      cpu_id = rq_pop();
      cpu_busy = 1'b1;
      slice_cnt = 0;
      r.dispatch_valid = 1'b1;
      r.dispatch_id = cpu_id;
    end
    r.all_done = (term_cnt >= total_reg);
    return r;
  endfunction

  // Model update, result check and beat bookkeeping at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      rq_head = 0;
      rq_tail = 0;
      rq_count = 0;
      cpu_busy = 1'b0;
      cpu_id = '0;
      slice_cnt = 0;
      term_cnt = 0;
      quantum_reg = QUANTUM_RESET;
      total_reg = TOTAL_RESET;
      beat_taken = 1'b0;
    end else begin
      if (result_valid === 1'b1) begin
        if (outcome_q.size() == 0) begin
          $error("result strobed with no event outstanding");
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (dispatch_valid !== want.dispatch_valid) begin
            $error("dispatch_valid: expected %0b, got %0b", want.dispatch_valid, dispatch_valid);
            errors++;
          end
          if (dispatch_id !== want.dispatch_id) begin
            $error("dispatch_id: expected %h, got %h", want.dispatch_id, dispatch_id);
            errors++;
          end
          if (preempt_valid !== want.preempt_valid) begin
            $error("preempt_valid: expected %0b, got %0b", want.preempt_valid, preempt_valid);
            errors++;
          end
          if (preempt_id !== want.preempt_id) begin
            $error("preempt_id: expected %h, got %h", want.preempt_id, preempt_id);
            errors++;
          end
          if (all_done !== want.all_done) begin
            $error("all_done: expected %0b, got %0b", want.all_done, all_done);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_SLICE_LIMIT:   quantum_reg = cfg_data;
          CFG_PROCESS_TOTAL: total_reg = cfg_data;
          default: ;
        endcase
      end
      beat_taken = start && !busy;
      if (beat_taken) begin
        got_outcome = schedule_event(mode, proc_id);
        outcome_q.push_back(got_outcome);
        events_accepted++;
        if (got_outcome.dispatch_valid) n_dispatch++;
        if (got_outcome.preempt_valid) n_preempt++;
        case (got_outcome.status)
          ST_FULL:       n_full++;
          ST_UNEXPECTED: n_unexp++;
          ST_AFTER_DONE: n_after++;
          default: ;
        endcase
      end
    end
  end

  // Driver: one event per beat, random gaps between beats.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !beat_taken) begin
        // Beat not yet taken, hold it.
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (event_q.size() > 0) begin
        next_ev = event_q.pop_front();
        start <= 1'b1;
        mode <= next_ev.mode;
        // The model state here is exactly what this beat will meet, so an
        // I/O request or termination can be aimed at the running process.
        if (next_ev.aim && cpu_busy &&
            (next_ev.mode == MODE_IO_REQ || next_ev.mode == MODE_TERM))
          proc_id <= cpu_id;
        else
          proc_id <= next_ev.id;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: gap_left = 0;
          9:             gap_left = $urandom_range(8, 40);
          default:       gap_left = $urandom_range(1, 3);
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_event(logic [2:0] ev_mode, logic [15:0] ev_id, bit aim);
    event_q.push_back('{ev_mode, ev_id, aim});
    events_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (events_accepted != events_queued || outcome_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(int count, bit flood);
    sched_event_t ev;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      ev.aim = ($urandom_range(0, 99) < 85);
      if (pick < (flood ? 45 : 22))      ev.mode = MODE_READY;
      else if (pick < (flood ? 55 : 32)) ev.mode = MODE_IO_DONE;
      else if (pick < (flood ? 62 : 44)) ev.mode = MODE_IO_REQ;
      else if (pick < (flood ? 65 : 52)) ev.mode = MODE_TERM;
      else if (pick < 98)                ev.mode = MODE_TICK;
      else                               ev.mode = 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 19);
      if (pick == 0)     ev.id = 16'hFFFF;
      else if (pick < 3) ev.id = 16'($urandom_range(0, 65535));
      else               ev.id = 16'($urandom_range(0, 31));
      event_q.push_back(ev);
      events_queued++;
    end
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(CFG_SLICE_LIMIT, 16'd2);
    write_reg(CFG_PROCESS_TOTAL, 16'd3);
    add_event(MODE_TICK, 16'h0000, 1'b0);
    add_event(MODE_IO_REQ, 16'h0005, 1'b0);
    add_event(MODE_TERM, 16'hFFFF, 1'b0);
    add_event(3'd5, 16'h0005, 1'b0);
    add_event(3'd6, 16'h0006, 1'b0);
    add_event(3'd7, 16'hAAAA, 1'b0);
    add_event(MODE_READY, 16'h0000, 1'b0);
    add_event(MODE_READY, 16'hFFFF, 1'b0);
    add_event(MODE_IO_DONE, 16'h1234, 1'b0);
    add_event(MODE_TICK, 16'h0000, 1'b0);
    add_event(MODE_TICK, 16'h5555, 1'b0);
    add_event(MODE_IO_REQ, 16'h0001, 1'b0);
    add_event(MODE_IO_REQ, 16'h0000, 1'b1);
    add_event(MODE_TERM, 16'h0000, 1'b1);
    add_event(MODE_TERM, 16'h0000, 1'b1);
    add_event(MODE_READY, 16'h0007, 1'b0);
    add_event(MODE_TICK, 16'h0000, 1'b0);
    // Quantum expires with an empty queue: the same process comes back.
    add_event(MODE_TICK, 16'h0000, 1'b0);
    add_event(MODE_READY, 16'h0007, 1'b0);
    // Reaches the total with a process still queued.
    add_event(MODE_TERM, 16'h0000, 1'b1);
    add_event(MODE_READY, 16'h0009, 1'b0);
    add_event(MODE_TICK, 16'h0000, 1'b0);
    wait_idle();

    write_reg(CFG_PROCESS_TOTAL, 16'd0);
    run_phase(15, 1'b0);
    write_reg(CFG_SLICE_LIMIT, 16'd0);
    write_reg(CFG_PROCESS_TOTAL, 16'(term_cnt + 40));
    run_phase(150, 1'b0);
    write_reg(CFG_SLICE_LIMIT, 16'd1);
    write_reg(CFG_PROCESS_TOTAL, 16'(term_cnt + 30));
    run_phase(200, 1'b1);
    write_reg(CFG_SLICE_LIMIT, 16'd3);
    write_reg(CFG_PROCESS_TOTAL, 16'hFFFF);
    run_phase(250, 1'b0);
    write_reg(CFG_SLICE_LIMIT, 16'hFFFF);
    write_reg(CFG_PROCESS_TOTAL, 16'(term_cnt + 20));
    run_phase(150, 1'b0);
    repeat (4) begin
      write_reg(CFG_SLICE_LIMIT, 16'($urandom_range(1, 8)));
      write_reg(CFG_PROCESS_TOTAL, 16'(term_cnt + $urandom_range(2, 10)));
      run_phase(120, 1'($urandom_range(0, 1)));
    end
    write_reg(CFG_SLICE_LIMIT, 16'd100);
    write_reg(CFG_PROCESS_TOTAL, 16'(term_cnt + 10));
    run_phase(50, 1'b0);

    $display("Ran %0d events: %0d dispatches, %0d preemptions, %0d terminations.",
             events_accepted, n_dispatch, n_preempt, term_cnt);
    $display("Dropped on full queue: %0d, unexpected: %0d, ignored after done: %0d.",
             n_full, n_unexp, n_after);
    if (errors == 0)
      $display("round_robin_scheduler: match");
    else
      $display("round_robin_scheduler: mismatch");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out waiting for the scheduler.");
    $display("round_robin_scheduler: mismatch");
    $finish;
  end

endmodule
